/* design/lz78_dictionary_encoder_top_macros.svh */
// ----------------------------------------------------------------------------
// LZ78 encoder assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef LZ78_DICTIONARY_ENCODER_TOP_MACROS_SVH
`define LZ78_DICTIONARY_ENCODER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LZD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LZD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LZD_ASSERT_SAME(lbl, ante, cons, msg)
`define LZD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/lzd_pkg.sv */
// ----------------------------------------------------------------------------
// LZ78 encoder package
// Controller states, command and status bundles, shared helpers.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int SYM_W     = 8;
    localparam int WIDTH_IN_W = 17;

    localparam int END_CODE   = 0;
    localparam int ROOT_CODE  = 1;
    localparam int FIRST_CODE = 2;

    localparam logic OP_SYMBOL = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD,
        S_REV,
        S_FLUSH,
        S_EMIT_MID,
        S_STOP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic rev_read;
        logic resolve;
        logic flush_pair;
        logic load_stop;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic pending;
        logic flush;
    } status_t;

    function automatic logic [4:0] width_of(logic [WIDTH_IN_W-1:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < WIDTH_IN_W; i++)
        begin
            if (v[i])
            begin
                n = 5'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

/* design/lzd_if.sv */
// ----------------------------------------------------------------------------
// LZ78 encoder channels
// Input symbol channel and output code channel with valid/ready.
// ----------------------------------------------------------------------------
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] symbol;

    modport source (output valid, output operation, output symbol, input ready);
    modport sink   (input valid, input operation, input symbol, output ready);
endinterface

interface lzd_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] code;
    logic [7:0]  pair_symbol;
    logic [3:0]  code_bits;
    logic        last;

    modport source (output valid, output code, output pair_symbol, output code_bits,
                    output last, input ready);
    modport sink   (input valid, input code, input pair_symbol, input code_bits,
                    input last, output ready);
endinterface

/* design/lz78_dictionary_encoder_top.sv */
// ----------------------------------------------------------------------------
// LZ78 dictionary encoder, top level
// One byte per request: a symbol passes through accept, key -> child code
// read, and code -> key check and update; a miss adds delivery of its
// result. A flush delivers one or two results: the pending pair, if any,
// then the stop code. One request is in flight at a time.
// Dictionary clears on full and at stream end need no clearing pass.
// ----------------------------------------------------------------------------
`include "lz78_dictionary_encoder_top_macros.svh"

module lz78_dictionary_encoder_top
#(
    parameter int CODE_BITS = 12
)
(
    input logic      clk,
    input logic      rst_n,
    lzd_in_if.sink   symbols,
    lzd_out_if.source codes
);

    lzd_pkg::cmd_t    cmd;
    lzd_pkg::status_t status;

    lzd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (symbols.valid),
        .in_ready  (symbols.ready),
        .out_valid (codes.valid),
        .out_ready (codes.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lzd_dp #(.CODE_BITS(CODE_BITS)) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_operation    (symbols.operation),
        .in_symbol       (symbols.symbol),
        .out_code        (codes.code),
        .out_pair_symbol (codes.pair_symbol),
        .out_code_bits   (codes.code_bits),
        .out_last        (codes.last)
    );

    `LZD_ASSERT_SAME(a_no_overlap, codes.valid, !symbols.ready, "accept while result pending")
    `LZD_ASSERT_SAME(a_bits_nonzero, codes.valid, codes.code_bits != 4'd0, "zero code width")
    `LZD_ASSERT_SAME(a_stop_code, codes.valid && codes.last, codes.code == 12'(lzd_pkg::END_CODE), "bad stop")
    `LZD_ASSERT_NEXT(a_idle_after_stop, codes.valid && codes.ready && codes.last, symbols.ready, "not idle after stop")

endmodule

/* design/lzd_ctrl.sv */
// ----------------------------------------------------------------------------
// LZ78 encoder controller
// Sequences lookup, update, flush and result delivery.
// ----------------------------------------------------------------------------
module lzd_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  lzd_pkg::status_t status,
    output lzd_pkg::cmd_t    cmd
);

    lzd_pkg::state_t state_reg;
    lzd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.flush ? lzd_pkg::S_FLUSH : lzd_pkg::S_FWD;
                end
            end
            lzd_pkg::S_FWD:
            begin
                state_next = lzd_pkg::S_REV;
            end
            lzd_pkg::S_REV:
            begin
                state_next = status.hit ? lzd_pkg::S_IDLE : lzd_pkg::S_EMIT;
            end
            lzd_pkg::S_FLUSH:
            begin
                state_next = status.pending ? lzd_pkg::S_EMIT_MID : lzd_pkg::S_STOP;
            end
            lzd_pkg::S_EMIT_MID:
            begin
                if (out_ready)
                begin
                    state_next = lzd_pkg::S_STOP;
                end
            end
            lzd_pkg::S_STOP:
            begin
                state_next = lzd_pkg::S_EMIT;
            end
            lzd_pkg::S_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = lzd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lzd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            lzd_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            lzd_pkg::S_FWD:
            begin
                cmd.rev_read = 1'b1;
            end
            lzd_pkg::S_REV:
            begin
                cmd.resolve = 1'b1;
            end
            lzd_pkg::S_FLUSH:
            begin
                cmd.flush_pair = status.pending;
            end
            lzd_pkg::S_EMIT_MID:
            begin
                out_valid = 1'b1;
            end
            lzd_pkg::S_STOP:
            begin
                cmd.load_stop = 1'b1;
            end
            lzd_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* design/lzd_dp.sv */
// ----------------------------------------------------------------------------
// LZ78 encoder datapath
// Phrase state, key-indexed child table, code-indexed key table, result register.
// ----------------------------------------------------------------------------
module lzd_dp
#(
    parameter int CODE_BITS = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lzd_pkg::cmd_t    cmd,
    output lzd_pkg::status_t status,
    input  logic             in_operation,
    input  logic [7:0]       in_symbol,
    output logic [11:0]      out_code,
    output logic [7:0]       out_pair_symbol,
    output logic [3:0]       out_code_bits,
    output logic             out_last
);

    localparam int KEY_W     = CODE_BITS + lzd_pkg::SYM_W;
    localparam int FWD_DEPTH = 1 << KEY_W;
    localparam int REV_DEPTH = 1 << CODE_BITS;

    // key -> child code; confirmed against the code -> key table
    logic [CODE_BITS-1:0] fwd_mem [FWD_DEPTH];
    logic [KEY_W-1:0]     rev_mem [REV_DEPTH];

    logic [CODE_BITS-1:0] cur_reg,  cur_next;
    logic [CODE_BITS-1:0] prev_reg, prev_next;
    logic [7:0]           psym_reg, psym_next;
    logic [CODE_BITS-1:0] nfc_reg,  nfc_next;
    logic                 op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [CODE_BITS-1:0] fwd_q_reg;
    logic [KEY_W-1:0]     rev_q_reg;

    logic [11:0] oc_reg;
    logic [7:0]  os_reg;
    logic [3:0]  ob_reg;
    logic        ol_reg;

    logic [CODE_BITS:0]   nfc_inc;
    logic [CODE_BITS-1:0] nfc_wrap;
    logic                 hit;

    assign nfc_inc  = {1'b0, nfc_reg} + (CODE_BITS+1)'(1);
    assign nfc_wrap = nfc_inc[CODE_BITS] ? CODE_BITS'(lzd_pkg::FIRST_CODE)
                                         : nfc_inc[CODE_BITS-1:0];

    assign hit = (rev_q_reg == key_reg)
              && (fwd_q_reg >= CODE_BITS'(lzd_pkg::FIRST_CODE))
              && (fwd_q_reg < nfc_reg);

    assign status.hit     = hit;
    assign status.pending = (cur_reg != CODE_BITS'(lzd_pkg::ROOT_CODE));
    assign status.flush   = (in_operation == lzd_pkg::OP_FLUSH);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            fwd_q_reg <= fwd_mem[{cur_reg, in_symbol}];
            key_reg   <= {cur_reg, in_symbol};
            op_reg    <= in_operation;
        end
        if (cmd.rev_read)
        begin
            rev_q_reg <= rev_mem[fwd_q_reg];
        end
        if (cmd.resolve && !hit)
        begin
            fwd_mem[key_reg] <= nfc_reg;
            rev_mem[nfc_reg] <= key_reg;
        end
    end

    always_comb
    begin
        cur_next  = cur_reg;
        prev_next = prev_reg;
        psym_next = psym_reg;
        nfc_next  = nfc_reg;
        if (cmd.resolve)
        begin
            psym_next = key_reg[7:0];
            if (hit)
            begin
                prev_next = cur_reg;
                cur_next  = fwd_q_reg;
            end
            else
            begin
                nfc_next = nfc_wrap;
                cur_next = CODE_BITS'(lzd_pkg::ROOT_CODE);
            end
        end
        else if (cmd.flush_pair)
        begin
            nfc_next = nfc_wrap;
        end
        else if (cmd.load_stop)
        begin
            cur_next  = CODE_BITS'(lzd_pkg::ROOT_CODE);
            prev_next = '0;
            psym_next = '0;
            nfc_next  = CODE_BITS'(lzd_pkg::FIRST_CODE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= CODE_BITS'(lzd_pkg::ROOT_CODE);
            prev_reg <= '0;
            psym_reg <= '0;
            nfc_reg  <= CODE_BITS'(lzd_pkg::FIRST_CODE);
        end
        else
        begin
            cur_reg  <= cur_next;
            prev_reg <= prev_next;
            psym_reg <= psym_next;
            nfc_reg  <= nfc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resolve && !hit)
        begin
            oc_reg <= 12'(cur_reg);
            os_reg <= key_reg[7:0];
            ob_reg <= 4'(lzd_pkg::width_of(17'(nfc_reg)));
            ol_reg <= 1'b0;
        end
        else if (cmd.flush_pair)
        begin
            oc_reg <= 12'(prev_reg);
            os_reg <= psym_reg;
            ob_reg <= 4'(lzd_pkg::width_of(17'(nfc_reg)));
            ol_reg <= 1'b0;
        end
        else if (cmd.load_stop)
        begin
            oc_reg <= 12'(lzd_pkg::END_CODE);
            os_reg <= '0;
            ob_reg <= 4'(lzd_pkg::width_of(17'(nfc_reg)));
            ol_reg <= op_reg;
        end
    end

    assign out_code        = oc_reg;
    assign out_pair_symbol = os_reg;
    assign out_code_bits   = ob_reg;
    assign out_last        = ol_reg;

endmodule
